// ===== hdl/dzv_pkg.sv =====
// Shared types and constants of the delta zigzag varint encoder.
// No dependencies; used by dzv_serializer and delta_zigzag_varint_encoder.
package dzv_pkg;

	// width of the write offset register
	localparam int OFFSET_BITS = 16;
	// largest offset the register holds
	localparam logic [OFFSET_BITS-1:0] OFFSET_LIMIT = {OFFSET_BITS{1'b1}};
	// width for the fit check: wide enough for the offset or the capacity plus a carry
	localparam int CMP_W = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 1;

	localparam int CODE_W = 32;
	localparam int LEN_W = 3;
	localparam int GROUP_BITS = 7;
	localparam logic [7:0] MORE_BIT = 8'h80;
	localparam logic [LEN_W-1:0] MAX_BYTES = 3'd5;
	localparam logic [LEN_W-1:0] ONE_BYTE = 3'd1;

	// one encoded record handed to the output serializer
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0] len;
		logic [OFFSET_BITS-1:0] offset;
		logic [15:0] count;
		logic accepted;
	} load_t;

endpackage

// ===== hdl/dzv_serializer.sv =====
// Output serializer: takes one encoded record and emits its bytes one per cycle while out_ready is high.
// Depends on dzv_pkg for the record struct and constants.
module dzv_serializer (
	input  logic clk,
	input  logic arst_n,
	input  logic load_valid,
	output logic load_ready,
	input  dzv_pkg::load_t load,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] out_byte,
	output logic [15:0] byte_offset,
	output logic accepted,
	output logic last,
	output logic [15:0] count
);

	logic valid_q;
	logic [dzv_pkg::CODE_W-1:0] code_q;
	logic [dzv_pkg::LEN_W-1:0] left_q;
	logic [dzv_pkg::OFFSET_BITS-1:0] off_q;
	logic [15:0] cnt_q;
	logic acc_q;
	logic is_last;
	logic out_xfer;

	assign is_last = (left_q == dzv_pkg::ONE_BYTE);
	assign out_xfer = valid_q && out_ready;
	// take a new record when empty or when the final byte leaves now
	assign load_ready = !valid_q || (out_ready && is_last);

	// control: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	// payload: load a record, or advance to the next byte
	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			code_q <= load.code;
			left_q <= load.len;
			off_q <= load.offset;
			cnt_q <= load.count;
			acc_q <= load.accepted;
		end else if (out_xfer && !is_last) begin
			code_q <= code_q >> dzv_pkg::GROUP_BITS;
			left_q <= left_q - dzv_pkg::ONE_BYTE;
			off_q <= off_q + dzv_pkg::OFFSET_BITS'(1);
		end
	end

	// drive the result fields
	assign out_valid = valid_q;
	assign out_byte = {!is_last, code_q[dzv_pkg::GROUP_BITS-1:0]};
	assign byte_offset = 16'(off_q);
	assign accepted = acc_q;
	assign last = is_last;
	assign count = cnt_q;

	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (left_q != '0) && (left_q <= dzv_pkg::MAX_BYTES))
		else $error("byte count out of range");

	a_reject_single: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !acc_q) |-> (is_last && (code_q == '0)))
		else $error("rejection is not a single zero byte");

	a_byte_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && !is_last) |=>
		(valid_q && (off_q == $past(off_q) + dzv_pkg::OFFSET_BITS'(1))
		 && (left_q == $past(left_q) - dzv_pkg::ONE_BYTE)))
		else $error("byte offset did not advance");

endmodule

// ===== hdl/delta_zigzag_varint_encoder.sv =====
// Top level of the delta zigzag varint encoder: input register, encoder state, fit check.
// Depends on dzv_pkg and dzv_serializer.
//
// Each accepted 32-bit value is turned into the delta from the previous accepted
// value, zigzag mapped and LEB128 encoded into 1 to 5 bytes, which leave on the
// output one byte per transaction with their buffer offsets, the accepted flag,
// the record count and last on the final byte. A record that would pass the
// capacity gives one zero byte with accepted low and changes no state. A record
// of 1 to 5 bytes (a rejection 1) holds the output until all its bytes have left
// the byte-wide output serializer; a new value is taken while the previous record
// is still being emitted. The value passes the input register and the serializer
// register before its first byte is presented. capacity resets to 65535; the user
// must write it only while the block is idle; the block itself does not enforce it.
module delta_zigzag_varint_encoder (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [31:0] value,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] out_byte,
	output logic [15:0] byte_offset,
	output logic accepted,
	output logic last,
	output logic [15:0] count
);

	localparam logic [31:0] LIM1 = 32'h0000_0080;
	localparam logic [31:0] LIM2 = 32'h0000_4000;
	localparam logic [31:0] LIM3 = 32'h0020_0000;
	localparam logic [31:0] LIM4 = 32'h1000_0000;

	logic [15:0] capacity_q;
	logic [dzv_pkg::OFFSET_BITS-1:0] wr_off_q;
	logic [31:0] prev_q;
	logic [15:0] records_q;
	logic vld_s1;
	logic [31:0] val_s1;

	logic load_ready;
	logic load_fire;
	dzv_pkg::load_t load;
	logic [31:0] delta;
	logic [31:0] zz;
	logic [dzv_pkg::LEN_W-1:0] len;
	logic [dzv_pkg::CMP_W-1:0] end_off;
	logic [dzv_pkg::CMP_W-1:0] limit;
	logic [dzv_pkg::CMP_W-1:0] cap_ext;
	logic [dzv_pkg::CMP_W-1:0] off_lim_ext;
	logic fits;
	logic [15:0] next_count;

	// hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 16'hFFFF;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	// input register stage
	assign in_ready = !vld_s1 || load_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			val_s1 <= value;
		end
	end

	// delta, zigzag map and byte count
	assign delta = val_s1 - prev_q;
	assign zz = {delta[30:0], 1'b0} ^ {32{delta[31]}};

	always_comb begin
		priority if (zz < LIM1) begin
			len = 3'd1;
		end else if (zz < LIM2) begin
			len = 3'd2;
		end else if (zz < LIM3) begin
			len = 3'd3;
		end else if (zz < LIM4) begin
			len = 3'd4;
		end else begin
			len = dzv_pkg::MAX_BYTES;
		end
	end

	// check the record against the smaller of capacity and the offset range
	assign cap_ext = dzv_pkg::CMP_W'(capacity_q);
	assign off_lim_ext = dzv_pkg::CMP_W'(dzv_pkg::OFFSET_LIMIT);
	assign limit = (cap_ext < off_lim_ext) ? cap_ext : off_lim_ext;
	assign end_off = dzv_pkg::CMP_W'(wr_off_q) + dzv_pkg::CMP_W'(len);
	assign fits = (end_off <= limit);
	assign next_count = records_q + 16'd1;

	// build the record for the serializer
	always_comb begin
		load.offset = wr_off_q;
		load.accepted = fits;
		if (fits) begin
			load.code = zz;
			load.len = len;
			load.count = next_count;
		end else begin
			load.code = '0;
			load.len = dzv_pkg::ONE_BYTE;
			load.count = records_q;
		end
	end

	assign load_fire = vld_s1 && load_ready;

	// advance the encoder state on an appended record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_off_q <= '0;
			prev_q <= '0;
			records_q <= '0;
		end else if (load_fire && fits) begin
			wr_off_q <= dzv_pkg::OFFSET_BITS'(end_off);
			prev_q <= val_s1;
			records_q <= next_count;
		end
	end

	dzv_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (vld_s1),
		.load_ready (load_ready),
		.load       (load),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_offset(byte_offset),
		.accepted   (accepted),
		.last       (last),
		.count      (count)
	);

	a_state_hold_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(load_fire && !fits) |=>
		($stable(wr_off_q) && $stable(prev_q) && $stable(records_q)))
		else $error("state changed on a rejected record");

	a_offset_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(load_fire && fits) |=> (dzv_pkg::CMP_W'(wr_off_q) <= $past(limit)))
		else $error("write offset passed the limit");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(load_fire && fits) |=> (records_q == $past(records_q) + 16'd1))
		else $error("record count did not step");

endmodule
